### sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit pool allocator
// Transfer payloads, cell operations, status codes and controller states.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int FREE_SLOTS_DEF  = 16;
    localparam int ALLOC_SLOTS_DEF = 32;
    localparam int LEN_BITS_DEF    = 17;

    localparam int          ADDR_W        = 32;
    localparam int          SIZE_W        = 17;
    localparam int          CNT_W         = 6;
    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 32;
    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FIT   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PULL,
        CELL_PUSH
    } cell_op_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_RSCAN,
        S_PSCAN,
        S_MERGE,
        S_JOIN,
        S_RDEL,
        S_DONE
    } fsm_e;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] alloc_size;
        logic [ADDR_W-1:0] free_addr;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
        logic [SIZE_W-1:0] free_bytes;
        logic [CNT_W-1:0]  live_allocs;
    } out_item_t;

endpackage

### sv/ffpa_cell.sv
// ----------------------------------------------------------------------------
// ffpa_cell: one table entry
// Holds one entry and loads, takes its right neighbor or its left neighbor.
// ----------------------------------------------------------------------------
module ffpa_cell #(
    parameter int             W       = 8,
    parameter int             IW      = 1,
    parameter int             INDEX   = 0,
    parameter logic [W-1:0]   RST_VAL = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffpa_pkg::cell_op_e op,
    input  logic [IW-1:0]      idx,
    input  logic [W-1:0]       wdata,
    input  logic [W-1:0]       left,
    input  logic [W-1:0]       right,
    output logic [W-1:0]       q
);
    import ffpa_pkg::*;

    localparam logic [IW-1:0] ME = IW'(INDEX);

    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (op)
            CELL_LOAD:
            begin
                if (idx == ME)
                    q_next = wdata;
            end
            CELL_PULL:
            begin
                if (ME >= idx)
                    q_next = right;
            end
            CELL_PUSH:
            begin
                if (ME > idx)
                    q_next = left;
                else if (ME == idx)
                    q_next = wdata;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= RST_VAL;
        else
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### sv/ffpa_row.sv
// ----------------------------------------------------------------------------
// ffpa_row: a row of table cells
// Chains the cells to their neighbors and selects one entry for reading.
// ----------------------------------------------------------------------------
module ffpa_row #(
    parameter int           W     = 8,
    parameter int           SLOTS = 2,
    parameter int           IW    = 1,
    parameter logic [W-1:0] RST0  = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffpa_pkg::cell_op_e op,
    input  logic [IW-1:0]      idx,
    input  logic [W-1:0]       wdata,
    input  logic [IW-1:0]      rd_idx,
    output logic [W-1:0]       rd_data
);
    import ffpa_pkg::*;

    logic [W-1:0] q [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [W-1:0] lft;
        logic [W-1:0] rgt;

        if (i == 0)
        begin : g_first
            assign lft = '0;
        end
        else
        begin : g_mid_l
            assign lft = q[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign rgt = '0;
        end
        else
        begin : g_mid_r
            assign rgt = q[i+1];
        end

        ffpa_cell #(
            .W       (W),
            .IW      (IW),
            .INDEX   (i),
            .RST_VAL ((i == 0) ? RST0 : '0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (op),
            .idx   (idx),
            .wdata (wdata),
            .left  (lft),
            .right (rgt),
            .q     (q[i])
        );
    end

    assign rd_data = q[rd_idx];

endmodule

### sv/first_fit_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core: first-fit byte pool allocator
// Keeps a sorted, coalescing free table and a table of live allocations.
//
// Input transfers carry func, alloc_size and free_addr; output transfers carry
// addr, status, free_bytes and live_allocs, one result per input item.
// The block takes one item at a time. in_stall is high from acceptance until
// the result has been placed in the output register, which may still hold an
// earlier result waiting on out_stall when the next item is accepted.
// An allocate scans the free segments in order until one fits or the table
// ends. A free scans the records for the address, then the free table for
// the insertion point, merges with a neighbor or inserts (with a further
// join step when it merges with both), and then drops the record.
// Each scan step reads one table entry through the row's read select.
// A stalled result holds in the output register and the controller waits.
// Reset sets the pool to base 0 and 65536 bytes with one free segment and no
// records. A configuration write re-initializes both tables.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core #(
    parameter int FREE_SLOTS  = ffpa_pkg::FREE_SLOTS_DEF,
    parameter int ALLOC_SLOTS = ffpa_pkg::ALLOC_SLOTS_DEF,
    parameter int LEN_BITS    = ffpa_pkg::LEN_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ffpa_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ffpa_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ffpa_pkg::*;

    localparam int LB  = LEN_BITS;
    localparam int SW  = ADDR_W + LB;
    localparam int IWF = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int IWA = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
    localparam int CWF = $clog2(FREE_SLOTS + 1);
    localparam int CWA = $clog2(ALLOC_SLOTS + 1);
    localparam logic [LB-1:0]  SIZE_RST  = LB'(POOL_SIZE_RST);
    localparam logic [CWF-1:0] SEGS_RST  = (SIZE_RST != '0) ? CWF'(1) : '0;
    localparam logic [CWF-1:0] FREE_MAX  = CWF'(FREE_SLOTS);
    localparam logic [CWA-1:0] ALLOC_MAX = CWA'(ALLOC_SLOTS);

    fsm_e state_reg, state_next;

    logic [ADDR_W-1:0] pool_base_reg, pool_base_next;
    logic [LB-1:0]     pool_size_reg, pool_size_next;
    logic [CWF-1:0]    seg_count_reg, seg_count_next;
    logic [CWA-1:0]    rec_count_reg, rec_count_next;
    logic [LB-1:0]     free_bytes_reg, free_bytes_next;
    logic [CWF-1:0]    sidx_reg, sidx_next;
    logic [CWA-1:0]    ridx_reg, ridx_next;
    logic              func_reg, func_next;
    logic [LB-1:0]     size_reg, size_next;
    logic [ADDR_W-1:0] a_reg, a_next;
    logic [LB-1:0]     len_reg, len_next;
    logic [ADDR_W-1:0] prev_start_reg, prev_start_next;
    logic [LB-1:0]     prev_len_reg, prev_len_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_e           res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    cell_op_e          seg_op, rec_op;
    logic [IWF-1:0]    seg_idx;
    logic [IWA-1:0]    rec_idx;
    logic [SW-1:0]     seg_wd, rec_wd, seg_rd, rec_rd;
    logic [ADDR_W-1:0] seg_start_rd, rec_start_rd, prev_end;
    logic [LB-1:0]     seg_len_rd, rec_len_rd;

    logic accept, cfg_hit, a_end, a_hit, r_end, r_hit, p_in, p_stop, ml, mr;
    logic out_free;

    ffpa_row #(
        .W     (SW),
        .SLOTS (FREE_SLOTS),
        .IW    (IWF),
        .RST0  ({ADDR_W'(0), SIZE_RST})
    ) u_free_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (seg_op),
        .idx     (seg_idx),
        .wdata   (seg_wd),
        .rd_idx  (sidx_reg[IWF-1:0]),
        .rd_data (seg_rd)
    );

    ffpa_row #(
        .W     (SW),
        .SLOTS (ALLOC_SLOTS),
        .IW    (IWA),
        .RST0  ('0)
    ) u_rec_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (rec_op),
        .idx     (rec_idx),
        .wdata   (rec_wd),
        .rd_idx  (ridx_reg[IWA-1:0]),
        .rd_data (rec_rd)
    );

    assign seg_start_rd = seg_rd[SW-1 -: ADDR_W];
    assign seg_len_rd   = seg_rd[LB-1:0];
    assign rec_start_rd = rec_rd[SW-1 -: ADDR_W];
    assign rec_len_rd   = rec_rd[LB-1:0];
    assign prev_end     = prev_start_reg + ADDR_W'(prev_len_reg);

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign cfg_hit = cfg_we && ((cfg_index == CFG_POOL_BASE) || (cfg_index == CFG_POOL_SIZE));
    assign a_end   = (sidx_reg == seg_count_reg);
    assign a_hit   = (seg_len_rd >= size_reg);
    assign r_end   = (ridx_reg == rec_count_reg);
    assign r_hit   = (rec_start_rd == a_reg);
    assign p_in    = (sidx_reg < seg_count_reg);
    assign p_stop  = !p_in || ((seg_start_rd - pool_base_reg) >= (a_reg - pool_base_reg));
    assign ml      = (sidx_reg != '0) && (prev_end == a_reg);
    assign mr      = p_in && ((a_reg + ADDR_W'(len_reg)) == seg_start_rd);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func)
                        state_next = S_RSCAN;
                    else if ((LB'(in_data.alloc_size) == '0) || (rec_count_reg == ALLOC_MAX))
                        state_next = S_DONE;
                    else
                        state_next = S_ASCAN;
                end
            end
            S_ASCAN:
            begin
                if (a_end || a_hit)
                    state_next = S_DONE;
            end
            S_RSCAN:
            begin
                if (r_end)
                    state_next = S_DONE;
                else if (r_hit)
                    state_next = S_PSCAN;
            end
            S_PSCAN:
            begin
                if (p_stop)
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (ml && mr)
                    state_next = S_JOIN;
                else if (!ml && !mr && (seg_count_reg == FREE_MAX))
                    state_next = S_DONE;
                else
                    state_next = S_RDEL;
            end
            S_JOIN:
            begin
                state_next = S_RDEL;
            end
            S_RDEL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pool_base_next  = pool_base_reg;
        pool_size_next  = pool_size_reg;
        seg_count_next  = seg_count_reg;
        rec_count_next  = rec_count_reg;
        free_bytes_next = free_bytes_reg;
        sidx_next       = sidx_reg;
        ridx_next       = ridx_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        a_next          = a_reg;
        len_next        = len_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        res_addr_next   = res_addr_reg;
        res_stat_next   = res_stat_reg;
        seg_op          = CELL_HOLD;
        seg_idx         = '0;
        seg_wd          = '0;
        rec_op          = CELL_HOLD;
        rec_idx         = '0;
        rec_wd          = '0;

        if (cfg_hit)
        begin
            if (cfg_index == CFG_POOL_BASE)
                pool_base_next = cfg_data;
            else
                pool_size_next = LB'(cfg_data[SIZE_W-1:0]);
            seg_op          = CELL_LOAD;
            seg_wd          = {pool_base_next, pool_size_next};
            seg_count_next  = (pool_size_next != '0) ? CWF'(1) : '0;
            rec_count_next  = '0;
            free_bytes_next = pool_size_next;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_next     = in_data.func;
                        size_next     = LB'(in_data.alloc_size);
                        a_next        = in_data.free_addr;
                        sidx_next     = '0;
                        ridx_next     = '0;
                        res_addr_next = '0;
                        if (!in_data.func && (LB'(in_data.alloc_size) == '0))
                            res_stat_next = STAT_NO_FIT;
                        else if (!in_data.func && (rec_count_reg == ALLOC_MAX))
                            res_stat_next = STAT_FULL;
                        else
                            res_stat_next = STAT_OK;
                    end
                end
                S_ASCAN:
                begin
                    if (a_end)
                        res_stat_next = STAT_NO_FIT;
                    else if (a_hit)
                    begin
                        res_addr_next   = seg_start_rd;
                        rec_op          = CELL_LOAD;
                        rec_idx         = rec_count_reg[IWA-1:0];
                        rec_wd          = {seg_start_rd, size_reg};
                        rec_count_next  = rec_count_reg + CWA'(1);
                        free_bytes_next = free_bytes_reg - size_reg;
                        seg_idx         = sidx_reg[IWF-1:0];
                        if (seg_len_rd != size_reg)
                        begin
                            seg_op = CELL_LOAD;
                            seg_wd = {seg_start_rd + ADDR_W'(size_reg), seg_len_rd - size_reg};
                        end
                        else
                        begin
                            seg_op         = CELL_PULL;
                            seg_count_next = seg_count_reg - CWF'(1);
                        end
                    end
                    else
                        sidx_next = sidx_reg + CWF'(1);
                end
                S_RSCAN:
                begin
                    if (r_end)
                        res_stat_next = STAT_NOT_FOUND;
                    else if (r_hit)
                        len_next = rec_len_rd;
                    else
                        ridx_next = ridx_reg + CWA'(1);
                end
                S_PSCAN:
                begin
                    if (!p_stop)
                    begin
                        prev_start_next = seg_start_rd;
                        prev_len_next   = seg_len_rd;
                        sidx_next       = sidx_reg + CWF'(1);
                    end
                end
                S_MERGE:
                begin
                    if (ml)
                    begin
                        seg_op  = CELL_LOAD;
                        seg_idx = IWF'(sidx_reg - CWF'(1));
                        if (mr)
                            seg_wd = {prev_start_reg, prev_len_reg + len_reg + seg_len_rd};
                        else
                            seg_wd = {prev_start_reg, prev_len_reg + len_reg};
                    end
                    else if (mr)
                    begin
                        seg_op  = CELL_LOAD;
                        seg_idx = sidx_reg[IWF-1:0];
                        seg_wd  = {a_reg, seg_len_rd + len_reg};
                    end
                    else if (seg_count_reg == FREE_MAX)
                        res_stat_next = STAT_FULL;
                    else
                    begin
                        seg_op         = CELL_PUSH;
                        seg_idx        = sidx_reg[IWF-1:0];
                        seg_wd         = {a_reg, len_reg};
                        seg_count_next = seg_count_reg + CWF'(1);
                    end
                end
                S_JOIN:
                begin
                    seg_op         = CELL_PULL;
                    seg_idx        = sidx_reg[IWF-1:0];
                    seg_count_next = seg_count_reg - CWF'(1);
                end
                S_RDEL:
                begin
                    rec_op          = CELL_PULL;
                    rec_idx         = ridx_reg[IWA-1:0];
                    rec_count_next  = rec_count_reg - CWA'(1);
                    free_bytes_next = free_bytes_reg + len_reg;
                    res_addr_next   = a_reg;
                end
                default:
                begin
                    res_stat_next = res_stat_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next            = 1'b1;
            out_data_next.addr        = res_addr_reg;
            out_data_next.status      = res_stat_reg;
            out_data_next.free_bytes  = SIZE_W'(free_bytes_reg);
            out_data_next.live_allocs = CNT_W'(rec_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_base_reg  <= '0;
            pool_size_reg  <= SIZE_RST;
            seg_count_reg  <= SEGS_RST;
            rec_count_reg  <= '0;
            free_bytes_reg <= SIZE_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_base_reg  <= pool_base_next;
            pool_size_reg  <= pool_size_next;
            seg_count_reg  <= seg_count_next;
            rec_count_reg  <= rec_count_next;
            free_bytes_reg <= free_bytes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sidx_reg       <= sidx_next;
        ridx_reg       <= ridx_next;
        func_reg       <= func_next;
        size_reg       <= size_next;
        a_reg          <= a_next;
        len_reg        <= len_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        res_addr_reg   <= res_addr_next;
        res_stat_reg   <= res_stat_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_count_reg <= FREE_MAX)
        else $error("free table count exceeds its slots");

    a_rec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count_reg <= ALLOC_MAX)
        else $error("record count exceeds its slots");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_bytes_reg <= pool_size_reg)
        else $error("free bytes exceed the pool size");

    a_alloc_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ASCAN) |-> !func_reg)
        else $error("free item entered the allocate scan");

endmodule

### sim/tb_first_fit_pool_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator_core: self-checking bench for the pool allocator
// A queue of pending requests feeds a clocked driver and a clocked monitor
// checks every result transfer against an in-bench model of the free segment
// table and the allocation records, over several pool configurations.
// ----------------------------------------------------------------------------
module tb_first_fit_pool_allocator_core;
    import ffpa_pkg::*;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;
    localparam int NSEG = FREE_SLOTS_DEF;
    localparam int NREC = ALLOC_SLOTS_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    first_fit_pool_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_item_t  request_q[$];
    out_item_t result_q[$];
    bit quiet;
    int errors;
    int gap_left;
    int stall_left;
    int idle_cycles;
    int stat_seen[4];

    logic [ADDR_W-1:0] pool_base_m;
    logic [SIZE_W-1:0] pool_size_m;
    logic [ADDR_W-1:0] seg_start_m[NSEG];
    logic [SIZE_W-1:0] seg_len_m[NSEG];
    int seg_cnt;
    logic [ADDR_W-1:0] rec_start_m[NREC];
    logic [SIZE_W-1:0] rec_len_m[NREC];
    int rec_cnt;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void tables_init();
        for (int i = 0; i < NSEG; i++)
        begin
            seg_start_m[i] = '0;
            seg_len_m[i] = '0;
        end
        seg_start_m[0] = pool_base_m;
        seg_len_m[0] = pool_size_m;
        seg_cnt = (pool_size_m != 0) ? 1 : 0;
        rec_cnt = 0;
    endfunction

    function automatic out_item_t pool_apply(in_item_t it);
        out_item_t res;
        status_e st;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] key;
        logic [SIZE_W-1:0] len;
        int r;
        int p;
        int total;
        bit ml;
        bit mr;
        st = STAT_NO_FIT;
        a = '0;
        r = 0;
        p = 0;
        total = 0;
        if (it.func == FN_ALLOC)
        begin
            if (it.alloc_size == 0)
                st = STAT_NO_FIT;
            else if (rec_cnt >= NREC)
                st = STAT_FULL;
            else
            begin
                for (int i = 0; i < seg_cnt; i++)
                begin
                    if (st == STAT_NO_FIT && seg_len_m[i] >= it.alloc_size)
                    begin
                        st = STAT_OK;
                        a = seg_start_m[i];
                        rec_start_m[rec_cnt] = a;
                        rec_len_m[rec_cnt] = it.alloc_size;
                        rec_cnt++;
                        if (seg_len_m[i] != it.alloc_size)
                        begin
                            seg_start_m[i] = seg_start_m[i] + it.alloc_size;
                            seg_len_m[i] = seg_len_m[i] - it.alloc_size;
                        end
                        else
                        begin
                            for (int j = i; j + 1 < seg_cnt; j++)
                            begin
                                seg_start_m[j] = seg_start_m[j + 1];
                                seg_len_m[j] = seg_len_m[j + 1];
                            end
                            seg_cnt--;
                        end
                    end
                end
            end
        end
        else
        begin
            st = STAT_NOT_FOUND;
            r = -1;
            for (int i = 0; i < rec_cnt; i++)
                if (r < 0 && rec_start_m[i] == it.free_addr)
                    r = i;
            if (r >= 0)
            begin
                a = it.free_addr;
                len = rec_len_m[r];
                key = a - pool_base_m;
                while (p < seg_cnt && ADDR_W'(seg_start_m[p] - pool_base_m) < key)
                    p++;
                ml = (p > 0) && (ADDR_W'(seg_start_m[p - 1] + seg_len_m[p - 1]) == a);
                mr = (p < seg_cnt) && (ADDR_W'(a + len) == seg_start_m[p]);
                st = STAT_OK;
                if (ml && mr)
                begin
                    seg_len_m[p - 1] = seg_len_m[p - 1] + len + seg_len_m[p];
                    for (int j = p; j + 1 < seg_cnt; j++)
                    begin
                        seg_start_m[j] = seg_start_m[j + 1];
                        seg_len_m[j] = seg_len_m[j + 1];
                    end
                    seg_cnt--;
                end
                else if (ml)
                    seg_len_m[p - 1] = seg_len_m[p - 1] + len;
                else if (mr)
                begin
                    seg_start_m[p] = a;
                    seg_len_m[p] = seg_len_m[p] + len;
                end
                else if (seg_cnt >= NSEG)
                    st = STAT_FULL;
                else
                begin
                    for (int j = seg_cnt; j > p; j--)
                    begin
                        seg_start_m[j] = seg_start_m[j - 1];
                        seg_len_m[j] = seg_len_m[j - 1];
                    end
                    seg_start_m[p] = a;
                    seg_len_m[p] = len;
                    seg_cnt++;
                end
                if (st == STAT_OK)
                begin
                    for (int j = r; j + 1 < rec_cnt; j++)
                    begin
                        rec_start_m[j] = rec_start_m[j + 1];
                        rec_len_m[j] = rec_len_m[j + 1];
                    end
                    rec_cnt--;
                end
            end
        end
        for (int i = 0; i < seg_cnt; i++)
            total += seg_len_m[i];
        res.addr = (st == STAT_OK) ? a : '0;
        res.status = st;
        res.free_bytes = SIZE_W'(total);
        res.live_allocs = CNT_W'(rec_cnt);
        return res;
    endfunction

    task automatic queue_request(logic fn, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] a);
        in_item_t it;
        it.func = fn;
        it.alloc_size = (fn == FN_ALLOC) ? size : SIZE_W'($urandom);
        it.free_addr = (fn == FN_FREE) ? a : $urandom;
        result_q = {result_q, pool_apply(it)};
        request_q = {request_q, it};
    endtask

    task automatic drain();
        wait (result_q.size() == 0 && request_q.size() == 0 && !in_valid);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE)
            pool_base_m = val;
        else
            pool_size_m = val[SIZE_W-1:0];
        tables_init();
        @(posedge clk);
    endtask

    task automatic random_mix(int n);
        int pick;
        int hi;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 9);
            if ((rec_cnt == 0 && pick < 1) || (rec_cnt >= NREC - 4 && pick < 7)
                || (rec_cnt > 0 && rec_cnt < NREC - 4 && pick < 4))
            begin
                if (rec_cnt > 0 && $urandom_range(0, 9) < 8)
                    a = rec_start_m[$urandom_range(0, rec_cnt - 1)];
                else if ($urandom_range(0, 1) == 0)
                    a = pool_base_m + $urandom_range(0, pool_size_m);
                else
                    a = $urandom;
                queue_request(FN_FREE, '0, a);
            end
            else
            begin
                hi = (pool_size_m > 16) ? pool_size_m / 16 : 1;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    size = SIZE_W'($urandom);
                else if (pick == 1)
                    size = '0;
                else if (pick < 12)
                    size = SIZE_W'($urandom_range(1, hi));
                else
                    size = SIZE_W'($urandom_range(1, 64));
                queue_request(FN_ALLOC, size, '0);
            end
        end
    endtask

    task automatic fragment_run();
        int order[$];
        for (int k = 0; k <= NREC; k++)
            queue_request(FN_ALLOC, 17'd2, '0);
        for (int k = 0; k < NSEG; k++)
            queue_request(FN_FREE, '0, pool_base_m + 4 * k);
        for (int k = 0; k < NREC; k++)
            order = {order, k};
        order.shuffle();
        foreach (order[i])
            queue_request(FN_FREE, '0, pool_base_m + 2 * order[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= request_q.pop_front();
                if (!quiet && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: addr %h status %0d",
                           out_data.addr, out_data.status);
                    errors++;
                end
                else
                begin
                    out_item_t exp;
                    exp = result_q.pop_front();
                    stat_seen[out_data.status]++;
                    if (out_data.addr !== exp.addr)
                    begin
                        $error("addr: expected %h, got %h", exp.addr, out_data.addr);
                        errors++;
                    end
                    if (out_data.status !== exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, out_data.status);
                        errors++;
                    end
                    if (out_data.free_bytes !== exp.free_bytes)
                    begin
                        $error("free_bytes: expected %0d, got %0d",
                               exp.free_bytes, out_data.free_bytes);
                        errors++;
                    end
                    if (out_data.live_allocs !== exp.live_allocs)
                    begin
                        $error("live_allocs: expected %0d, got %0d",
                               exp.live_allocs, out_data.live_allocs);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        errors = 0;
        idle_cycles = 0;
        pool_base_m = '0;
        pool_size_m = POOL_SIZE_RST;
        tables_init();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(FN_ALLOC, '0, '0);
        queue_request(FN_ALLOC, 17'd65536, '0);
        queue_request(FN_ALLOC, 17'd1, '0);
        queue_request(FN_FREE, '0, 32'd0);
        queue_request(FN_FREE, '0, 32'd0);
        queue_request(FN_ALLOC, 17'd100, '0);
        queue_request(FN_ALLOC, 17'd200, '0);
        queue_request(FN_ALLOC, 17'd300, '0);
        queue_request(FN_FREE, '0, 32'd100);
        queue_request(FN_FREE, '0, 32'hFFFF_FFFF);
        queue_request(FN_ALLOC, 17'd50, '0);
        queue_request(FN_FREE, '0, 32'd300);
        queue_request(FN_FREE, '0, 32'd0);
        queue_request(FN_FREE, '0, 32'd50);
        queue_request(FN_ALLOC, 17'h1FFFF, '0);
        queue_request(FN_ALLOC, 17'd65535, '0);
        queue_request(FN_FREE, '0, 32'd0);

        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        random_mix(110);
        write_reg(CFG_POOL_SIZE, 32'd100);
        write_reg(CFG_POOL_BASE, $urandom);
        fragment_run();
        random_mix(30);
        write_reg(CFG_POOL_SIZE, 32'd0);
        random_mix(12);
        write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_POOL_SIZE, 32'd512);
        random_mix(110);
        write_reg(CFG_POOL_BASE, 32'd0);
        write_reg(CFG_POOL_SIZE, 32'd65536);
        quiet = 1'b1;
        random_mix(90);

        wait (result_q.size() == 0 && request_q.size() == 0 && !in_valid);
        repeat (60) @(posedge clk);
        $display("Checked %0d results: %0d ok, %0d no fit, %0d not found, %0d table full,",
                 stat_seen[0] + stat_seen[1] + stat_seen[2] + stat_seen[3],
                 stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3]);
        $display("over wrapped, fragmented, empty and full-size pools; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### first_fit_pool_allocator_core.f
sv/ffpa_pkg.sv
sv/ffpa_cell.sv
sv/ffpa_row.sv
sv/first_fit_pool_allocator_core.sv
sim/tb_first_fit_pool_allocator_core.sv
